@@ rtl/pfed_pkg.sv @@
package pfed_pkg;

   // Defaults for the top-level parameters
   localparam int EventDepthDefault = 64;
   localparam int CountWidthDefault = 32;

   // Link word layout
   localparam int WordWidth = 40;
   localparam logic [14:0] SYNC_PATTERN = 15'h3C5C;
   localparam logic [1:0] SYNC_HEADER = 2'd0;
   localparam logic [1:0] SYNC_FILLER = 2'd2;

   // Buffered hit: word bits 38..0, bit 38 set means error code 2 or 3
   localparam int HitWidth = 39;

   // Pixel count store, one entry per {row, col}
   localparam int PixelCount = 256;
   localparam int PixelAddrWidth = 8;

   // Result transaction data: 71 field bits padded to 72
   localparam int RspDataWidth = 72;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

@@ rtl/pfed_ram.sv @@
module pfed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pixel_frame_event_deframer.sv @@
// Event deframer for 40-bit pixel detector link words.
// req_ channel: one link word per transaction in req_tdata; req_tlast high marks
//   a flush (end of run) and the word is then ignored.
// rsp_ channel: one committed hit per transaction; rsp_tlast marks the final hit
//   of the committed event.
// csr_: write csr_wr_en with csr_wr_data to set the channel tag for later hits.
// Timing: a word that commits nothing is taken with req_tready staying high. A header or flush
//   that commits a pending event starts a walk over the event buffer that keeps
//   req_tready low: each skipped entry passes a buffer read and a check, and each
//   emitted hit passes a buffer read, a count read and a count write back. The
//   first hit reaches the output register after the fetch, lookup and update states
//   at the earliest, each skipped entry ahead of it adding a fetch and a lookup.
// Reset: synchronous, active high. After reset a clearing pass writes zero into
//   all 256 pixel counters, one per cycle, and req_tready stays low until the pass
//   ends; csr writes are taken during that time.
// Stall: a result waits in the output register while rsp_tready is low; the
//   walk holds at the count write back until the register frees up. Input is
//   taken again once the walk ends, even while the last result still waits.
module pixel_frame_event_deframer
   import pfed_pkg::*;
#(
   parameter int EVENT_DEPTH = EventDepthDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // frame_word [39:0]
   input  logic [WordWidth-1:0]    req_tdata,
   input  logic                    req_tlast,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // hit_row [3:0], hit_col [7:4], arrival_code [17:8], width_code [26:18],
   // calib_code [36:27], error_code [37], channel_tag [38], pixel_hits [70:39],
   // zero pad [71]
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data
);

   localparam int AddrW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int FillW = $clog2(EVENT_DEPTH + 1);

   // Control state
   state_type                  state_ff, state_in;
   logic [PixelAddrWidth-1:0]  clr_addr_ff, clr_addr_in;
   logic                       channel_ff;
   logic [WordWidth-1:0]       prev_word_ff, prev_word_in;
   logic                       prev_valid_ff, prev_valid_in;
   logic                       synced_ff, synced_in;
   logic                       inside_ff, inside_in;
   logic                       pending_ff, pending_in;
   logic [FillW-1:0]           fill_ff, fill_in;
   logic [AddrW-1:0]           last_good_ff, last_good_in;
   logic [AddrW-1:0]           walk_idx_ff, walk_idx_in;
   logic [AddrW-1:0]           walk_last_ff, walk_last_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [RspDataWidth-1:0]    rsp_data_ff, rsp_data_in;

   // Input decode
   logic                       accept;
   logic [WordWidth-1:0]       word;
   logic                       is_dup, is_data, is_sync, got_header, is_unknown, got_trailer;
   logic                       proceed, do_store, do_commit;

   // Memories
   logic                       buf_we, buf_re;
   logic [HitWidth-1:0]        buf_rdata;
   logic                       cnt_we, cnt_re;
   logic [PixelAddrWidth-1:0]  cnt_waddr, pixel;
   logic [COUNT_WIDTH-1:0]     cnt_wdata, cnt_rdata, cnt_next;

   logic                       out_free, walk_done, hit_good;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign word       = req_tdata;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign walk_done  = (walk_idx_ff == walk_last_ff);
   assign hit_good   = !buf_rdata[38];
   assign pixel      = {buf_rdata[32:29], buf_rdata[36:33]};
   assign cnt_next   = (cnt_rdata == {COUNT_WIDTH{1'b1}}) ? cnt_rdata
                                                          : cnt_rdata + 1'b1;

   // Classify the incoming word
   always_comb begin
      is_dup      = prev_valid_ff && (word == prev_word_ff);
      is_data     = word[39];
      is_sync     = !word[39] && (word[38:24] == SYNC_PATTERN);
      got_header  = is_sync && (word[23:22] == SYNC_HEADER);
      is_unknown  = is_sync && (word[23:22] != SYNC_HEADER)
                            && (word[23:22] != SYNC_FILLER);
      got_trailer = !is_data && !is_sync;
      proceed     = accept && !req_tlast && !is_dup && !is_unknown
                    && (synced_ff || got_header);
      do_store    = proceed && is_data && inside_ff
                    && (fill_ff < FillW'(EVENT_DEPTH));
      // an empty pending event commits nothing
      do_commit   = pending_ff && (fill_ff != '0)
                    && ((accept && req_tlast) || (proceed && got_header));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == PixelAddrWidth'(PixelCount - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (do_commit) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (hit_good) begin
               state_in = ST_UPDATE;
            end else if (walk_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = walk_done ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      prev_word_in  = prev_word_ff;
      prev_valid_in = prev_valid_ff;
      synced_in     = synced_ff;
      inside_in     = inside_ff;
      pending_in    = pending_ff;
      fill_in       = fill_ff;
      last_good_in  = last_good_ff;
      walk_idx_in   = walk_idx_ff;
      walk_last_in  = walk_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;
      buf_we        = do_store;
      buf_re        = 1'b0;
      cnt_we        = 1'b0;
      cnt_re        = 1'b0;
      cnt_waddr     = pixel;
      cnt_wdata     = cnt_next;

      case (state_ff)
         ST_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_waddr   = clr_addr_ff;
            cnt_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept && req_tlast) begin
               pending_in = 1'b0;
            end
            if (accept && !req_tlast && !is_dup) begin
               prev_word_in  = word;
               prev_valid_in = 1'b1;
            end
            if (do_store) begin
               fill_in = fill_ff + 1'b1;
               if (!word[38]) begin
                  last_good_in = fill_ff[AddrW-1:0];
               end
            end
            if (proceed && got_header) begin
               synced_in  = 1'b1;
               inside_in  = 1'b1;
               pending_in = 1'b0;
               fill_in    = '0;
            end
            if (proceed && got_trailer && inside_ff) begin
               pending_in = 1'b1;
               inside_in  = 1'b0;
            end
            if (do_commit) begin
               walk_idx_in  = '0;
               walk_last_in = AddrW'(fill_ff - 1'b1);
            end
         end
         ST_FETCH: begin
            buf_re = 1'b1;
         end
         ST_LOOKUP: begin
            if (hit_good) begin
               cnt_re = 1'b1;
            end else if (!walk_done) begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cnt_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = (walk_idx_ff == last_good_ff);
               rsp_data_in  = {1'b0, 32'(cnt_next), channel_ff, buf_rdata[37],
                               buf_rdata[9:0], buf_rdata[18:10], buf_rdata[28:19],
                               buf_rdata[36:33], buf_rdata[32:29]};
               if (!walk_done) begin
                  walk_idx_in = walk_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            buf_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         channel_ff    <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_word_ff  <= '0;
         synced_ff     <= 1'b0;
         inside_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         if (csr_wr_en) begin
            channel_ff <= csr_wr_data;
         end
         prev_valid_ff <= prev_valid_in;
         prev_word_ff  <= prev_word_in;
         synced_ff     <= synced_in;
         inside_ff     <= inside_in;
         pending_ff    <= pending_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and walk registers need no reset
   always_ff @(posedge clock) begin
      last_good_ff <= last_good_in;
      walk_idx_ff  <= walk_idx_in;
      walk_last_ff <= walk_last_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Event buffer: hits of the open event, in arrival order
   pfed_ram #(
      .WIDTH(HitWidth),
      .DEPTH(EVENT_DEPTH)
   ) u_hit_buf (
      .clock  (clock),
      .wr_en  (buf_we),
      .wr_addr(fill_ff[AddrW-1:0]),
      .wr_data(word[HitWidth-1:0]),
      .rd_en  (buf_re),
      .rd_addr(walk_idx_ff),
      .rd_data(buf_rdata)
   );

   // Pixel hit counters, indexed by {row, col}
   pfed_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(PixelCount)
   ) u_pixel_cnt (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata),
      .rd_en  (cnt_re),
      .rd_addr(pixel),
      .rd_data(cnt_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(EVENT_DEPTH))
      else $error("event fill beyond buffer depth");

   a_event_flags: assert property (@(posedge clock) disable iff (reset)
      !(inside_ff && pending_ff))
      else $error("event both open and pending");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_LOOKUP || state_ff == ST_UPDATE)
      |-> (walk_idx_ff <= walk_last_ff))
      else $error("walk index past end of event");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during counter clearing pass");

   a_count_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && out_free) |=> rsp_valid_ff)
      else $error("counter update without result");
`endif

endmodule
